// ----- rtl/fpi_pkg.sv -----
// shared types and constants of the four-point sample interpolator
`timescale 1ns / 1ps

package fpi_pkg;

    // method register codes
    localparam int            METHOD_W       = 2;
    localparam logic [1:0]    METHOD_HERMITE = 2'd0;
    localparam logic [1:0]    METHOD_CUBIC   = 2'd1;
    localparam logic [1:0]    METHOD_LINEAR  = 2'd2;

    // input command codes
    localparam logic          CMD_EVAL       = 1'b0;
    localparam logic          CMD_PUSH       = 1'b1;

    // register port
    localparam int            APB_ADDR_W     = 3;
    localparam int            APB_DATA_W     = 32;
    localparam logic          REG_METHOD_IDX = 1'b0;

    // status of the queue between front and back
    typedef struct packed {
        logic full;
        logic valid;
    } q_status_t;

    // back end sequencer
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MAC,
        BK_FINISH
    } back_state_t;

endpackage

// ----- rtl/fpi_queue.sv -----
// two-entry queue of classified items between front and back
`timescale 1ns / 1ps

module fpi_queue import fpi_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output q_status_t        q_status
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    assign q_status.full  = (count_reg == 2'd2);
    assign q_status.valid = (count_reg != 2'd0);
    assign rd_data        = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- rtl/fpi_front.sv -----
// front end: sample window and polynomial coefficients per method
`timescale 1ns / 1ps

module fpi_front import fpi_pkg::*; #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int FRACTION_WIDTH = 16
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          s_valid,
    output logic                                          s_ready,
    input  logic                                          s_cmd,
    input  logic signed [SAMPLE_WIDTH-1:0]                s_new_sample,
    input  logic        [FRACTION_WIDTH-1:0]              s_fraction,
    input  logic        [METHOD_W-1:0]                    method,
    input  q_status_t                                     q_status,
    output logic                                          q_push,
    output logic [4*(SAMPLE_WIDTH+4)+FRACTION_WIDTH-1:0]  q_data
);

    localparam int DW = SAMPLE_WIDTH + 4;

    logic signed [SAMPLE_WIDTH-1:0] window_reg  [4];
    logic signed [SAMPLE_WIDTH-1:0] window_next [4];
    logic signed [DW-1:0]           x0, x1, x2, x3;
    logic signed [DW-1:0]           d0, d1, d2, d3;
    logic signed [DW-1:0]           a_term;
    logic signed [DW-1:0]           diff12;
    logic                           accept;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept;

    always_comb begin
        if (s_cmd == CMD_PUSH) begin
            window_next[0] = window_reg[1];
            window_next[1] = window_reg[2];
            window_next[2] = window_reg[3];
            window_next[3] = s_new_sample;
        end else begin
            window_next[0] = window_reg[0];
            window_next[1] = window_reg[1];
            window_next[2] = window_reg[2];
            window_next[3] = window_reg[3];
        end
    end

    assign x0 = DW'(window_next[0]);
    assign x1 = DW'(window_next[1]);
    assign x2 = DW'(window_next[2]);
    assign x3 = DW'(window_next[3]);

    // coefficients of the doubled polynomial d3 t^3 + d2 t^2 + d1 t + d0
    always_comb begin
        a_term = x3 - x2 - x0 + x1;
        diff12 = x1 - x2;
        unique case (method)
            METHOD_HERMITE: begin
                d0 = x1 <<< 1;
                d1 = x2 - x0;
                d2 = (x0 <<< 1) - ((x1 <<< 2) + x1) + (x2 <<< 2) - x3;
                d3 = x3 - x0 + (diff12 <<< 1) + diff12;
            end
            METHOD_CUBIC: begin
                d0 = x1 <<< 1;
                d1 = (x2 - x0) <<< 1;
                d2 = (x0 - x1 - a_term) <<< 1;
                d3 = a_term <<< 1;
            end
            default: begin
                // linear, also for the unused code
                d0 = x1 <<< 1;
                d1 = (x2 - x1) <<< 1;
                d2 = '0;
                d3 = '0;
            end
        endcase
    end

    assign q_data = {d3, d2, d1, d0, s_fraction};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                window_reg[i] <= '0;
            end
        end else if (accept) begin
            for (int i = 0; i < 4; i++) begin
                window_reg[i] <= window_next[i];
            end
        end
    end

endmodule

// ----- rtl/fpi_back.sv -----
// back end: chunked horner evaluation, rounding, saturation and output register
`timescale 1ns / 1ps

module fpi_back import fpi_pkg::*; #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int FRACTION_WIDTH = 16
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  q_status_t                                     q_status,
    input  logic [4*(SAMPLE_WIDTH+4)+FRACTION_WIDTH-1:0]  q_data,
    output logic                                          q_pop,
    output logic                                          m_valid,
    input  logic                                          m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]                m_sample_out,
    output logic                                          m_clipped
);

    localparam int DW     = SAMPLE_WIDTH + 4;
    localparam int QW     = 4 * DW + FRACTION_WIDTH;
    localparam int CW     = 32;
    localparam int AW     = SAMPLE_WIDTH + 5 + 3 * FRACTION_WIDTH;
    localparam int AWM    = SAMPLE_WIDTH + 5 + 2 * FRACTION_WIDTH;
    localparam int NCH    = (AWM + CW - 1) / CW;
    localparam int EW     = NCH * CW;
    localparam int ACC_W  = (AW > EW) ? AW : EW;
    localparam int PW     = CW + FRACTION_WIDTH + 2;
    localparam int XW     = (PW > ACC_W) ? PW : ACC_W;
    localparam int CNT_W  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int RND_SH = 3 * FRACTION_WIDTH + 1;

    localparam logic [1:0]       LAST_STEP = 2'd2;
    localparam logic [CNT_W-1:0] LAST_CHUNK = CNT_W'(NCH - 1);
    localparam logic [ACC_W-1:0] HALF =
        {{(ACC_W-1){1'b0}}, 1'b1} << (3 * FRACTION_WIDTH);
    localparam logic signed [ACC_W-1:0] SAT_MAX =
        {{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_MIN =
        {{(ACC_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

    back_state_t                     state_reg, state_next;
    logic        [CNT_W-1:0]         chunk_reg;
    logic        [1:0]               step_reg;
    logic        [EW-1:0]            opnd_reg;
    logic signed [ACC_W-1:0]         acc_reg;
    logic        [FRACTION_WIDTH-1:0] frac_reg;
    logic signed [DW-1:0]            d2_reg, d1_reg, d0_reg;
    logic                            m_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0]  sample_reg;
    logic                            clipped_reg;

    logic signed [DW-1:0]            d3_in, d2_in, d1_in, d0_in;
    logic        [FRACTION_WIDTH-1:0] frac_in;
    logic                            out_free;
    logic                            last_chunk;
    logic                            first_chunk;
    logic                            load_item;
    logic                            mac_en;
    logic                            finish_en;
    logic        [CW-1:0]            chunk;
    logic signed [CW:0]              mul_a;
    logic signed [FRACTION_WIDTH:0]  mul_b;
    logic signed [PW-1:0]            prod;
    logic signed [XW-1:0]            prod_x;
    logic signed [ACC_W-1:0]         prod_a;
    logic signed [ACC_W-1:0]         dterm;
    logic signed [ACC_W-1:0]         acc_shift;
    logic signed [ACC_W-1:0]         acc_sum;
    logic signed [ACC_W-1:0]         rnd;
    logic signed [ACC_W-1:0]         quot;

    assign d3_in   = q_data[QW-1 -: DW];
    assign d2_in   = q_data[QW-DW-1 -: DW];
    assign d1_in   = q_data[QW-2*DW-1 -: DW];
    assign d0_in   = q_data[QW-3*DW-1 -: DW];
    assign frac_in = q_data[FRACTION_WIDTH-1:0];

    assign out_free    = !m_valid_reg || m_ready;
    assign last_chunk  = (chunk_reg == LAST_CHUNK);
    assign first_chunk = (chunk_reg == '0);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (q_status.valid) begin
                    state_next = BK_MAC;
                end
            end
            BK_MAC: begin
                if (last_chunk && (step_reg == LAST_STEP)) begin
                    state_next = BK_FINISH;
                end
            end
            BK_FINISH: begin
                if (out_free) begin
                    state_next = q_status.valid ? BK_MAC : BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        load_item = 1'b0;
        mac_en    = 1'b0;
        finish_en = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                load_item = q_status.valid;
            end
            BK_MAC: begin
                mac_en = 1'b1;
            end
            BK_FINISH: begin
                finish_en = out_free;
                load_item = out_free && q_status.valid;
            end
            default: begin
                load_item = 1'b0;
            end
        endcase
    end

    assign q_pop = load_item;

    // one chunk of the operand times the fraction, top chunk signed
    assign chunk  = opnd_reg[EW-1 -: CW];
    assign mul_a  = first_chunk ? {chunk[CW-1], chunk} : {1'b0, chunk};
    assign mul_b  = {1'b0, frac_reg};
    assign prod   = mul_a * mul_b;
    assign prod_x = XW'(prod);
    assign prod_a = prod_x[ACC_W-1:0];

    always_comb begin
        unique case (step_reg)
            2'd0:    dterm = ACC_W'(d2_reg) << FRACTION_WIDTH;
            2'd1:    dterm = ACC_W'(d1_reg) << (2 * FRACTION_WIDTH);
            default: dterm = ACC_W'(d0_reg) << (3 * FRACTION_WIDTH);
        endcase
    end

    assign acc_shift = first_chunk ? '0 : (acc_reg << CW);
    assign acc_sum   = acc_shift + prod_a + (last_chunk ? dterm : '0);

    // round half away from zero: floor((A + half - neg) / 2^(3F+1))
    assign rnd  = acc_reg + HALF - {{(ACC_W-1){1'b0}}, acc_reg[ACC_W-1]};
    assign quot = rnd >>> RND_SH;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            chunk_reg   <= '0;
            step_reg    <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_item) begin
                chunk_reg <= '0;
                step_reg  <= 2'd0;
            end else if (mac_en) begin
                if (last_chunk) begin
                    chunk_reg <= '0;
                    step_reg  <= step_reg + 2'd1;
                end else begin
                    chunk_reg <= chunk_reg + CNT_W'(1);
                end
            end
            if (finish_en) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_item) begin
            opnd_reg <= EW'(d3_in);
            d2_reg   <= d2_in;
            d1_reg   <= d1_in;
            d0_reg   <= d0_in;
            frac_reg <= frac_in;
        end else if (mac_en) begin
            opnd_reg <= last_chunk ? acc_sum[EW-1:0] : (opnd_reg << CW);
        end
        if (mac_en) begin
            acc_reg <= acc_sum;
        end
        if (finish_en) begin
            if (quot > SAT_MAX) begin
                sample_reg  <= SAT_MAX[SAMPLE_WIDTH-1:0];
                clipped_reg <= 1'b1;
            end else if (quot < SAT_MIN) begin
                sample_reg  <= SAT_MIN[SAMPLE_WIDTH-1:0];
                clipped_reg <= 1'b1;
            end else begin
                sample_reg  <= quot[SAMPLE_WIDTH-1:0];
                clipped_reg <= 1'b0;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_sample_out = sample_reg;
    assign m_clipped    = clipped_reg;

endmodule

// ----- rtl/four_point_sample_interpolator.sv -----
// top level of the four-point sample interpolator with its register port
`timescale 1ns / 1ps

// channel   direction  handshake          payload
// s_        in         s_valid/s_ready    s_cmd, s_new_sample, s_fraction
// m_        out        m_valid/m_ready    m_sample_out, m_clipped
// apb       in         psel/penable       paddr, pwrite, pwdata, prdata, pready
//
// the front takes one beat per cycle while the two-entry queue has room
// the back runs each horner step (d2, d1, d0) through its shared chunk multiplier in NCH
// chunks, NCH = ceil((SAMPLE_WIDTH+5+2*FRACTION_WIDTH)/32), then rounds and saturates;
// NCH is 2 at the default widths
// a result waits in the output register while the back starts the next beat
// synchronous active-low reset clears the window to zero and method to hermite

module four_point_sample_interpolator import fpi_pkg::*; #(
    parameter int SAMPLE_WIDTH   = 16,
    parameter int FRACTION_WIDTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input beats
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_cmd,
    input  logic signed [SAMPLE_WIDTH-1:0]    s_new_sample,
    input  logic        [FRACTION_WIDTH-1:0]  s_fraction,
    // result beats
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]    m_sample_out,
    output logic                              m_clipped,
    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic        [APB_ADDR_W-1:0]      paddr,
    input  logic        [APB_DATA_W-1:0]      pwdata,
    output logic        [APB_DATA_W-1:0]      prdata,
    output logic                              pready
);

    localparam int DW = SAMPLE_WIDTH + 4;
    localparam int QW = 4 * DW + FRACTION_WIDTH;

    logic [METHOD_W-1:0] method_reg;
    logic                reg_sel;
    logic                reg_write;
    q_status_t           q_status;
    logic                q_push;
    logic                q_pop;
    logic [QW-1:0]       q_wr_data;
    logic [QW-1:0]       q_rd_data;

    // register access: only the method register exists, word index from paddr[2]
    assign pready    = 1'b1;
    assign reg_sel   = (paddr[2] == REG_METHOD_IDX);
    assign reg_write = psel && penable && pwrite && pready;
    assign prdata    = reg_sel ? {{(APB_DATA_W-METHOD_W){1'b0}}, method_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            method_reg <= METHOD_HERMITE;
        end else if (reg_write && reg_sel) begin
            method_reg <= pwdata[METHOD_W-1:0];
        end
    end

    // front: window update and coefficients
    fpi_front #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .FRACTION_WIDTH (FRACTION_WIDTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_new_sample (s_new_sample),
        .s_fraction   (s_fraction),
        .method       (method_reg),
        .q_status     (q_status),
        .q_push       (q_push),
        .q_data       (q_wr_data)
    );

    // decouples the front from the multi-cycle back
    fpi_queue #(
        .WIDTH (QW)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .wr_data  (q_wr_data),
        .pop      (q_pop),
        .rd_data  (q_rd_data),
        .q_status (q_status)
    );

    // back: horner in chunks, rounding and saturation
    fpi_back #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .FRACTION_WIDTH (FRACTION_WIDTH)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_status     (q_status),
        .q_data       (q_rd_data),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .m_clipped    (m_clipped)
    );

endmodule
